// File: sv/ldnw_pkg.sv
`default_nettype none

package ldnw_pkg;

  // Widths fixed by the request format.
  localparam int ROW_W    = 2;
  localparam int COLUMN_W = 6;
  localparam int NUMBER_W = 16;
  localparam int COUNT_W  = 3;
  localparam int NIBBLE_W = 4;
  localparam int BYTE_W   = 8;

  localparam int DEFAULT_MAX_DIGITS = 5;
  localparam int QUEUE_DEPTH        = 2;

  // Row codes that carry a cursor command.
  localparam logic [ROW_W-1:0] ROW_FIRST  = 2'd1;
  localparam logic [ROW_W-1:0] ROW_SECOND = 2'd2;

  // Set DDRAM address commands for the two display lines.
  localparam logic [BYTE_W-1:0] CMD_LINE_FIRST  = 8'h80;
  localparam logic [BYTE_W-1:0] CMD_LINE_SECOND = 8'hC0;
  localparam logic [BYTE_W-1:0] ASCII_ZERO      = 8'h30;

  // Register select levels on the LCD bus.
  localparam logic RS_COMMAND = 1'b0;
  localparam logic RS_DATA    = 1'b1;

  // Classified request handed from the front end to the sequencer.
  typedef struct packed {
    logic                has_cmd;
    logic [BYTE_W-1:0]   cmd;
    logic [COUNT_W-1:0]  count;
  } job_ctrl_t;

  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_CONVERT,
    FRONT_PUSH
  } front_state_t;

  typedef enum logic {
    BACK_IDLE,
    BACK_RUN
  } back_state_t;

endpackage

`default_nettype wire

// File: sv/ldnw_front.sv
`default_nettype none

module ldnw_front #(
  parameter int MAX_DIGITS = ldnw_pkg::DEFAULT_MAX_DIGITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [ldnw_pkg::ROW_W-1:0]        row,
  input  wire logic [ldnw_pkg::COLUMN_W-1:0]     column,
  input  wire logic [ldnw_pkg::NUMBER_W-1:0]     number,
  input  wire logic [ldnw_pkg::COUNT_W-1:0]      digit_count,
  output logic                                   push_valid,
  input  wire logic                              push_ready,
  output ldnw_pkg::job_ctrl_t                    push_ctrl,
  output logic [4*MAX_DIGITS-1:0]                push_bcd
);
  import ldnw_pkg::*;

  localparam int BCD_W = 4 * MAX_DIGITS;
  localparam int CNT_W = $clog2(NUMBER_W);

  front_state_t          state, state_next;
  logic [CNT_W-1:0]      bit_cnt;
  logic [NUMBER_W-1:0]   bin_shift;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      bcd_adj;
  job_ctrl_t             job;
  job_ctrl_t             job_in;
  logic                  accept;
  logic                  nothing;

  assign accept = in_valid && in_ready;

  always_comb begin
    job_in.has_cmd = (row == ROW_FIRST) || (row == ROW_SECOND);
    job_in.cmd     = ((row == ROW_FIRST) ? CMD_LINE_FIRST : CMD_LINE_SECOND)
                     + {{(BYTE_W-COLUMN_W){1'b0}}, column};
    job_in.count   = (digit_count > COUNT_W'(MAX_DIGITS)) ? COUNT_W'(MAX_DIGITS)
                                                          : digit_count;
  end

  assign nothing = !job_in.has_cmd && (job_in.count == '0);

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] > 4'd4) ? bcd[4*i +: 4] + 4'd3
                                                 : bcd[4*i +: 4];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      FRONT_IDLE: begin
        if (accept && !nothing) begin
          state_next = (job_in.count == '0) ? FRONT_PUSH : FRONT_CONVERT;
        end
      end
      FRONT_CONVERT: begin
        if (bit_cnt == CNT_W'(NUMBER_W - 1)) begin
          state_next = FRONT_PUSH;
        end
      end
      FRONT_PUSH: begin
        if (push_ready) begin
          state_next = FRONT_IDLE;
        end
      end
      default: state_next = FRONT_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == FRONT_IDLE);
    push_valid = (state == FRONT_PUSH);
    push_ctrl  = job;
    push_bcd   = bcd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FRONT_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == FRONT_IDLE) begin
      if (accept) begin
        job       <= job_in;
        bin_shift <= number;
        bcd       <= '0;
        bit_cnt   <= '0;
      end
    end else if (state == FRONT_CONVERT) begin
      bcd       <= {bcd_adj[BCD_W-2:0], bin_shift[NUMBER_W-1]};
      bin_shift <= {bin_shift[NUMBER_W-2:0], 1'b0};
      bit_cnt   <= bit_cnt + CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// File: sv/ldnw_queue.sv
`default_nettype none

module ldnw_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ldnw_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic [WIDTH-1:0]      rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]  slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = (fill != FILL_W'(DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + FILL_W'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// File: sv/ldnw_back.sv
`default_nettype none

module ldnw_back #(
  parameter int MAX_DIGITS = ldnw_pkg::DEFAULT_MAX_DIGITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          pop_valid,
  output logic                               pop_ready,
  input  wire ldnw_pkg::job_ctrl_t           pop_ctrl,
  input  wire logic [4*MAX_DIGITS-1:0]       pop_bcd,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_rs,
  output logic [ldnw_pkg::NIBBLE_W-1:0]      out_nibble,
  output logic                               out_last
);
  import ldnw_pkg::*;

  localparam int BCD_W  = 4 * MAX_DIGITS;
  localparam int SLOT_W = $clog2(2 * MAX_DIGITS + 2);

  back_state_t          state, state_next;
  job_ctrl_t            job;
  logic [BCD_W-1:0]     bcd;
  logic [SLOT_W-1:0]    slot;
  logic [SLOT_W-1:0]    last_slot;
  logic                 load_out;
  logic [COUNT_W-1:0]   digit_k;
  logic [COUNT_W-1:0]   digit_pos;
  logic [NIBBLE_W-1:0]  digit;
  logic [BYTE_W-1:0]    char_byte;
  logic                 nib_rs;
  logic [NIBBLE_W-1:0]  nib_val;

  assign load_out = (state == BACK_RUN) && (!out_valid || out_ready);

  // Slots 0 and 1 are the command byte, then two slots per digit.
  always_comb begin
    digit_k   = COUNT_W'((slot - SLOT_W'(2)) >> 1);
    digit_pos = job.count - COUNT_W'(1) - digit_k;
    digit     = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (digit_pos == COUNT_W'(i)) begin
        digit = bcd[4*i +: 4];
      end
    end
    char_byte = ASCII_ZERO + {{(BYTE_W-NIBBLE_W){1'b0}}, digit};
    if (slot < SLOT_W'(2)) begin
      nib_rs  = RS_COMMAND;
      nib_val = slot[0] ? job.cmd[NIBBLE_W-1:0] : job.cmd[BYTE_W-1:NIBBLE_W];
    end else begin
      nib_rs  = RS_DATA;
      nib_val = slot[0] ? char_byte[NIBBLE_W-1:0] : char_byte[BYTE_W-1:NIBBLE_W];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      BACK_IDLE: begin
        if (pop_valid) begin
          state_next = BACK_RUN;
        end
      end
      BACK_RUN: begin
        if (load_out && (slot == last_slot)) begin
          state_next = BACK_IDLE;
        end
      end
      default: state_next = BACK_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = (state == BACK_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BACK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      job       <= pop_ctrl;
      bcd       <= pop_bcd;
      slot      <= pop_ctrl.has_cmd ? SLOT_W'(0) : SLOT_W'(2);
      last_slot <= SLOT_W'({pop_ctrl.count, 1'b1});
    end else if (load_out) begin
      slot <= slot + SLOT_W'(1);
    end
    if (load_out) begin
      out_rs     <= nib_rs;
      out_nibble <= nib_val;
      out_last   <= (slot == last_slot);
    end
  end

endmodule

`default_nettype wire

// File: sv/lcd_decimal_number_writer_core.sv
`default_nettype none

// Channel   Dir  Beat contents
// --------  ---  ------------------------------------------------------------
// s_*       in   one request: row, column, number, digit count
// m_*       out  one LCD bus nibble: nibble in tdata, register select in tuser,
//                tlast on the final nibble of a request
//
// The front end takes a request and, when digits are wanted, runs the number
// through a shift-and-add-three binary to decimal converter, one bit of the
// number per cycle; it then hands the job to a two-entry queue and takes no
// new request until the queue has taken it. The back end sequencer sends one
// nibble per cycle while m_tready holds, up to twelve per request, from a
// registered output stage. Reset clears the state machines, queue and output
// valid. Either side may stall on its own: the queue absorbs the difference,
// and a request that sends nothing gives no beat on the master side.

module lcd_decimal_number_writer_core #(
  parameter int MAX_DIGITS = ldnw_pkg::DEFAULT_MAX_DIGITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [1:0] row, [7:2] column, [23:8] number, [26:24] digit_count, rest zero
  input  wire logic [31:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [3:0] nibble, rest zero
  output logic [7:0]       m_tdata,
  // [0] reg_select
  output logic             m_tuser,
  output logic             m_tlast
);
  import ldnw_pkg::*;

  localparam int BCD_W   = 4 * MAX_DIGITS;
  localparam int CTRL_W  = $bits(job_ctrl_t);
  localparam int QUEUE_W = CTRL_W + BCD_W;

  job_ctrl_t           push_ctrl;
  logic [BCD_W-1:0]    push_bcd;
  logic                push_valid;
  logic                push_ready;
  logic [QUEUE_W-1:0]  pop_data;
  logic                pop_valid;
  logic                pop_ready;
  job_ctrl_t           pop_ctrl;
  logic [BCD_W-1:0]    pop_bcd;
  logic [NIBBLE_W-1:0] nibble;

  assign pop_ctrl = job_ctrl_t'(pop_data[QUEUE_W-1:BCD_W]);
  assign pop_bcd  = pop_data[BCD_W-1:0];
  assign m_tdata  = {{(8-NIBBLE_W){1'b0}}, nibble};

  // Classifies each request and converts the number to decimal digits.
  ldnw_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .row         (s_tdata[1:0]),
    .column      (s_tdata[7:2]),
    .number      (s_tdata[23:8]),
    .digit_count (s_tdata[26:24]),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_ctrl   (push_ctrl),
    .push_bcd    (push_bcd)
  );

  ldnw_queue #(
    .WIDTH (QUEUE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  ({push_ctrl, push_bcd}),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  // Steps through the command and digit bytes, high nibble first.
  ldnw_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_ctrl   (pop_ctrl),
    .pop_bcd    (pop_bcd),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_rs     (m_tuser),
    .out_nibble (nibble),
    .out_last   (m_tlast)
  );

endmodule

`default_nettype wire
